// ----- design/conv3x3_saturating_filter_defines.svh -----
// ----------------------------------------------------------------------------
// conv3x3 saturating filter assertion macros
// Concurrent check wrappers shared by the filter modules; they expand to
// nothing when the design is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_SATURATING_FILTER_DEFINES_SVH
`define CONV3X3_SATURATING_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CFSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfsf check failed");

// next-cycle implication
`define CFSF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfsf check failed");

`else

`define CFSF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CFSF_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- design/cfsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsf_pkg
// Shared constants, register indexes and beat / pipeline types of the filter.
// ----------------------------------------------------------------------------
package cfsf_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int LINE_DEPTH = 4096;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int LEN_W      = LINE_AW + 1;
   localparam int MAX_CH     = 4;
   localparam int CH_W       = $clog2(MAX_CH);
   localparam int TAPS       = 9;
   localparam int PROD_W     = 17;
   localparam int ROW_W      = 18;
   localparam int SUM_W      = 20;
   localparam int BEAT_W     = 3;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 16;
   localparam int CHAN_W     = 3;
   localparam int COEF_W     = 24;
   localparam int MIN_WIDTH  = 3;
   localparam int MAX_WIDTH  = 1024;
   localparam int MIN_HEIGHT = 3;

   localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH   = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = HEIGHT_W'(480);
   localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT = CHAN_W'(3);
   localparam logic [COEF_W-1:0]   RST_COEF_TOP      = 24'h00FF00;
   localparam logic [COEF_W-1:0]   RST_COEF_MID      = 24'hFF04FF;
   localparam logic [COEF_W-1:0]   RST_COEF_BOT      = 24'h00FF00;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_IMAGE_WIDTH   = 3'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT  = 3'd1;
   localparam csr_index_type CSR_CHANNEL_COUNT = 3'd2;
   localparam csr_index_type CSR_COEF_TOP_ROW  = 3'd3;
   localparam csr_index_type CSR_COEF_MID_ROW  = 3'd4;
   localparam csr_index_type CSR_COEF_BOT_ROW  = 3'd5;

   typedef struct packed {
      logic [SAMPLE_W-1:0] pixel_sample;
      logic                frame_start;
   } req_beat_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_sample;
      logic                run_last;
      logic                frame_last;
   } rsp_beat_type;

   typedef struct packed {
      logic [COEF_W-1:0] top;
      logic [COEF_W-1:0] mid;
      logic [COEF_W-1:0] bot;
   } coef_set_type;

   // what one sample causes on the result side
   typedef struct packed {
      logic              has_main;
      logic              interior;
      logic [CHAN_W-1:0] zero_cnt;
      logic              has_own;
      logic              frame_end;
   } ev_type;

   typedef struct packed {
      logic                valid;
      logic [LINE_AW-1:0]  addr;
      logic [SAMPLE_W-1:0] pix;
      logic [CH_W-1:0]     ch;
      ev_type              ev;
   } pos_type;

   typedef struct packed {
      logic                         valid;
      ev_type                       ev;
      logic [TAPS-1:0][PROD_W-1:0]  prod;
   } prod_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] val;
      logic [BEAT_W-1:0]   beats;
      logic                frame_end;
   } desc_type;

endpackage

// ----- design/cfsf_track.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsf_track
// Frame geometry, row and sample counters, and per-sample result flags.
// ----------------------------------------------------------------------------
`include "conv3x3_saturating_filter_defines.svh"

module cfsf_track import cfsf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  req_beat_type        req_beat,
   input  logic [WIDTH_W-1:0]  image_width,
   input  logic [HEIGHT_W-1:0] image_height,
   input  logic [CHAN_W-1:0]   channel_count,
   output pos_type             pos
);

   localparam int DIGITS = (LINE_AW + 1) / 2;

   logic [CHAN_W-1:0]   chans;
   logic [WIDTH_W-1:0]  pixels;
   logic [LEN_W-1:0]    row_len;
   logic [HEIGHT_W-1:0] rows;
   logic [LINE_AW-1:0]  last_col;
   logic [HEIGHT_W-1:0] last_row;

   logic [LINE_AW-1:0]  col_ff, col_in, col_start, col_cur;
   logic [HEIGHT_W-1:0] row_ff, row_in, row_start, row_cur;
   logic [HEIGHT_W:0]   row_step, row_next;
   logic [LEN_W-1:0]    col_next;

   logic                s1_valid_ff;
   logic [LINE_AW-1:0]  s1_col_ff;
   logic [HEIGHT_W-1:0] s1_row_ff;
   logic [SAMPLE_W-1:0] s1_pix_ff;

   logic [CH_W-1:0]     ch;
   logic                row_nz, row_end;
   ev_type              ev;

   function automatic logic [1:0] mod3(input logic [LINE_AW-1:0] v);
      logic [2*DIGITS-1:0] ve;
      logic [5:0]          acc;
      logic [3:0]          t;
      logic [2:0]          u;
      logic [1:0]          m;
      ve  = (2*DIGITS)'(v);
      acc = '0;
      for (int i = 0; i < DIGITS; i++) begin
         acc = acc + 6'(ve[2*i +: 2]);
      end
      t = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]);
      u = 3'(t[1:0]) + 3'(t[3:2]);
      case (u)
         3'd0, 3'd3: m = 2'd0;
         3'd1, 3'd4: m = 2'd1;
         3'd2, 3'd5: m = 2'd2;
         default:    m = 2'd0;
      endcase
      return m;
   endfunction

   // clamped geometry
   always_comb begin
      chans = channel_count;
      if (channel_count == '0) begin
         chans = CHAN_W'(1);
      end else if (channel_count > CHAN_W'(MAX_CH)) begin
         chans = CHAN_W'(MAX_CH);
      end
      pixels = image_width;
      if (image_width < WIDTH_W'(MIN_WIDTH)) begin
         pixels = WIDTH_W'(MIN_WIDTH);
      end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
         pixels = WIDTH_W'(MAX_WIDTH);
      end
      case (chans)
         3'd1:    row_len = LEN_W'(pixels);
         3'd2:    row_len = LEN_W'({pixels, 1'b0});
         3'd3:    row_len = LEN_W'(pixels) + LEN_W'({pixels, 1'b0});
         default: row_len = LEN_W'({pixels, 2'b00});
      endcase
      rows     = (image_height < HEIGHT_W'(MIN_HEIGHT)) ? HEIGHT_W'(MIN_HEIGHT) : image_height;
      last_col = LINE_AW'(row_len - 1'b1);
      last_row = rows - 1'b1;
   end

   // position of the incoming sample and the counters after it
   always_comb begin
      col_start = req_beat.frame_start ? '0 : col_ff;
      row_start = req_beat.frame_start ? '0 : row_ff;
      if ({1'b0, col_start} >= row_len) begin
         col_cur  = '0;
         row_step = {1'b0, row_start} + 1'b1;
      end else begin
         col_cur  = col_start;
         row_step = {1'b0, row_start};
      end
      row_cur  = (row_step >= {1'b0, rows}) ? '0 : row_step[HEIGHT_W-1:0];
      col_next = {1'b0, col_cur} + 1'b1;
      row_next = {1'b0, row_cur} + 1'b1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_next >= row_len) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, rows}) ? '0 : row_next[HEIGHT_W-1:0];
         end else begin
            col_in = col_next[LINE_AW-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_col_ff <= col_cur;
         s1_row_ff <= row_cur;
         s1_pix_ff <= req_beat.pixel_sample;
      end
   end

   // channel of the sample and what it emits
   always_comb begin
      case (chans)
         3'd1:    ch = '0;
         3'd2:    ch = CH_W'(s1_col_ff[0]);
         3'd3:    ch = mod3(s1_col_ff);
         default: ch = s1_col_ff[CH_W-1:0];
      endcase
      row_nz       = s1_row_ff != '0;
      row_end      = s1_col_ff == last_col;
      ev.has_main  = row_nz && ({1'b0, s1_col_ff} >= LEN_W'(chans));
      ev.interior  = (s1_row_ff >= HEIGHT_W'(2)) && ({1'b0, s1_col_ff} >= LEN_W'({chans, 1'b0}));
      ev.zero_cnt  = (row_nz && row_end) ? chans : '0;
      ev.has_own   = s1_row_ff == last_row;
      ev.frame_end = ev.has_own && row_end;
   end

   assign pos.valid = s1_valid_ff;
   assign pos.addr  = s1_col_ff;
   assign pos.pix   = s1_pix_ff;
   assign pos.ch    = ch;
   assign pos.ev    = ev;

   `CFSF_ASSERT_IMP(a_col_in_row, clock, reset, s1_valid_ff, s1_col_ff <= last_col)
   `CFSF_ASSERT_NXT(a_frame_start_home, clock, reset, accept && req_beat.frame_start, s1_col_ff == '0 && s1_row_ff == '0)

endmodule

// ----- design/cfsf_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsf_window
// Line memory (two previous rows per entry), per-channel 3x2 window and the
// nine coefficient products.
// ----------------------------------------------------------------------------
module cfsf_window import cfsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pos_type      pos,
   input  coef_set_type coefs,
   output prod_type     prod
);

   // word: older row in the upper byte, newer row in the lower byte
   logic [2*SAMPLE_W-1:0] line_mem [LINE_DEPTH];
   logic [2*SAMPLE_W-1:0] line_rd_ff;

   logic                  s2_valid_ff;
   logic [LINE_AW-1:0]    s2_addr_ff;
   logic [SAMPLE_W-1:0]   s2_pix_ff;
   logic [CH_W-1:0]       s2_ch_ff;
   ev_type                s2_ev_ff;
   logic                  s2_fwd_ff;
   logic [2*SAMPLE_W-1:0] s2_fwd_word_ff;

   logic [SAMPLE_W-1:0]   win_ff [MAX_CH][6];

   logic [2*SAMPLE_W-1:0] word;
   logic [SAMPLE_W-1:0]   up, mid;
   logic [SAMPLE_W-1:0]   taps  [TAPS];
   logic [SAMPLE_W-1:0]   cbyte [TAPS];
   logic [TAPS-1:0][PROD_W-1:0] prod_in;
   prod_type              prod_ff;

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         line_mem[s2_addr_ff] <= {mid, s2_pix_ff};
      end
      if (pos.valid) begin
         line_rd_ff <= line_mem[pos.addr];
      end
   end

   // the entry being written back now is forwarded to the next sample
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= pos.valid;
      end
      if (pos.valid) begin
         s2_addr_ff     <= pos.addr;
         s2_pix_ff      <= pos.pix;
         s2_ch_ff       <= pos.ch;
         s2_ev_ff       <= pos.ev;
         s2_fwd_ff      <= s2_valid_ff && (s2_addr_ff == pos.addr);
         s2_fwd_word_ff <= {mid, s2_pix_ff};
      end
   end

   always_comb begin
      word = s2_fwd_ff ? s2_fwd_word_ff : line_rd_ff;
      up   = word[2*SAMPLE_W-1:SAMPLE_W];
      mid  = word[SAMPLE_W-1:0];

      taps[0] = win_ff[s2_ch_ff][0];
      taps[1] = win_ff[s2_ch_ff][1];
      taps[2] = up;
      taps[3] = win_ff[s2_ch_ff][2];
      taps[4] = win_ff[s2_ch_ff][3];
      taps[5] = mid;
      taps[6] = win_ff[s2_ch_ff][4];
      taps[7] = win_ff[s2_ch_ff][5];
      taps[8] = s2_pix_ff;

      for (int k = 0; k < 3; k++) begin
         cbyte[k]     = coefs.top[k*SAMPLE_W +: SAMPLE_W];
         cbyte[k + 3] = coefs.mid[k*SAMPLE_W +: SAMPLE_W];
         cbyte[k + 6] = coefs.bot[k*SAMPLE_W +: SAMPLE_W];
      end

      for (int k = 0; k < TAPS; k++) begin
         prod_in[k] = PROD_W'($signed({{(PROD_W-SAMPLE_W){cbyte[k][SAMPLE_W-1]}}, cbyte[k]})
                            * $signed({{(PROD_W-SAMPLE_W){1'b0}}, taps[k]}));
      end
   end

   // shift the channel window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CH; i++) begin
            for (int k = 0; k < 6; k++) begin
               win_ff[i][k] <= '0;
            end
         end
      end else if (s2_valid_ff) begin
         win_ff[s2_ch_ff][0] <= win_ff[s2_ch_ff][1];
         win_ff[s2_ch_ff][1] <= up;
         win_ff[s2_ch_ff][2] <= win_ff[s2_ch_ff][3];
         win_ff[s2_ch_ff][3] <= mid;
         win_ff[s2_ch_ff][4] <= win_ff[s2_ch_ff][5];
         win_ff[s2_ch_ff][5] <= s2_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else begin
         prod_ff.valid <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         prod_ff.ev   <= s2_ev_ff;
         prod_ff.prod <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- design/cfsf_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsf_accum
// Sums the nine products in two steps, clamps to a byte and forms the
// result descriptor of each sample.
// ----------------------------------------------------------------------------
module cfsf_accum import cfsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  prod_type prod,
   output logic     push_valid,
   output desc_type push_desc
);

   logic signed [PROD_W-1:0] pv      [TAPS];
   logic signed [ROW_W-1:0]  row_sum [3];

   logic                     s4_valid_ff;
   logic signed [ROW_W-1:0]  s4_rows_ff [3];
   ev_type                   s4_ev_ff;

   logic signed [SUM_W-1:0]  total;
   logic                     neg, over;
   logic [SAMPLE_W-1:0]      clamped;

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         pv[k] = $signed(prod.prod[k]);
      end
      for (int i = 0; i < 3; i++) begin
         row_sum[i] = ROW_W'(pv[3*i]) + ROW_W'(pv[3*i + 1]) + ROW_W'(pv[3*i + 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= prod.valid;
      end
      if (prod.valid) begin
         s4_ev_ff <= prod.ev;
         for (int i = 0; i < 3; i++) begin
            s4_rows_ff[i] <= row_sum[i];
         end
      end
   end

   always_comb begin
      total   = SUM_W'(s4_rows_ff[0]) + SUM_W'(s4_rows_ff[1]) + SUM_W'(s4_rows_ff[2]);
      neg     = total[SUM_W-1];
      over    = !neg && (|total[SUM_W-2:SAMPLE_W]);
      clamped = neg ? '0 : (over ? '1 : total[SAMPLE_W-1:0]);

      push_desc.val       = s4_ev_ff.interior ? clamped : '0;
      push_desc.beats     = BEAT_W'(s4_ev_ff.has_main) + BEAT_W'(s4_ev_ff.zero_cnt)
                          + BEAT_W'(s4_ev_ff.has_own);
      push_desc.frame_end = s4_ev_ff.frame_end;
   end

   assign push_valid = s4_valid_ff;

endmodule

// ----- design/cfsf_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsf_out
// Descriptor queue and beat sequencer; expands each descriptor into its
// result beats behind a registered output.
// ----------------------------------------------------------------------------
`include "conv3x3_saturating_filter_defines.svh"

module cfsf_out import cfsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  desc_type     push_desc,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   desc_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]    cnt_ff, cnt_in;
   logic [BEAT_W-1:0]   beat_idx_ff;

   logic                rsp_valid_ff;
   rsp_beat_type        rsp_beat_ff;

   desc_type            head;
   logic                nonempty, can_load, last_beat, emit;

   always_comb begin
      head      = fifo_ff[rd_ptr_ff];
      nonempty  = cnt_ff != '0;
      can_load  = !rsp_valid_ff || rsp_ready;
      last_beat = beat_idx_ff == (head.beats - 1'b1);
      emit      = nonempty && (head.beats != '0) && can_load;
      // a sample with no result leaves the queue without a beat
      pop       = nonempty && ((head.beats == '0) || (can_load && last_beat));
      cnt_in    = cnt_ff + OCC_W'(push_valid) - OCC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         fifo_ff[wr_ptr_ff] <= push_desc;
      end
      if (emit) begin
         rsp_beat_ff.out_sample <= (beat_idx_ff == '0) ? head.val : '0;
         rsp_beat_ff.run_last   <= last_beat;
         rsp_beat_ff.frame_last <= last_beat && head.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         beat_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff   <= rd_ptr_ff + 1'b1;
            beat_idx_ff <= '0;
         end else if (emit) begin
            beat_idx_ff <= beat_idx_ff + 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   `CFSF_ASSERT_IMP(a_queue_room, clock, reset, push_valid, (cnt_ff < OCC_W'(FIFO_DEPTH)) || pop)
   `CFSF_ASSERT_IMP(a_beat_in_desc, clock, reset, nonempty && (head.beats != '0), beat_idx_ff < head.beats)

endmodule

// ----- design/conv3x3_saturating_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_saturating_filter
// 3x3 signed-coefficient convolution over an interleaved 8-bit raster
// stream, clamped to 0..255, zero on the frame border.
// ----------------------------------------------------------------------------
// Use:
//  req channel: one beat per channel sample, row-major with channels
//    interleaved; frame_start on the first sample of a frame restarts the
//    counters (a frame also wraps by itself after the last row).
//  rsp channel: result beats in raster order, one row behind the input;
//    run_last flags the last beat a sample causes, frame_last the last one
//    of the frame. A sample causes zero to six beats.
//  csr port: write-only, one register per index, written while no sample is
//    in flight.
// Path: a taken sample passes the position, window, product and row-sum
//  registers and the queue before its first beat enters the output register.
// Throughput: one sample per cycle while each causes at most one beat and
//  rsp_ready stays high; each result beat is loaded into the output register
//  on its own, so row-end zero beats and last-row own beats hold back the input.
// Reset: counters to row 0, windows cleared, registers to their defaults;
//  the line memory needs no clearing and is ready at once.
// Stall: at most eight samples are held between the input and the output
//  register; req_ready drops while eight are taken whose last beat has not
//  yet been loaded into the output register.
// ----------------------------------------------------------------------------
`include "conv3x3_saturating_filter_defines.svh"

module conv3x3_saturating_filter import cfsf_pkg::*; (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  req_beat_type        req_beat,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_beat_type        rsp_beat,

   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [COEF_W-1:0]   csr_wdata
);

   // configuration registers
   logic [WIDTH_W-1:0]  image_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;
   logic [CHAN_W-1:0]   channel_count_ff;
   logic [COEF_W-1:0]   coef_top_ff;
   logic [COEF_W-1:0]   coef_mid_ff;
   logic [COEF_W-1:0]   coef_bot_ff;

   // samples taken whose descriptor has not left the queue
   logic [OCC_W-1:0]    occ_ff, occ_in;

   logic                accept;
   logic                pop;
   logic                push_valid;
   desc_type            push_desc;
   pos_type             pos;
   prod_type            prod;
   coef_set_type        coefs;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= RST_IMAGE_WIDTH;
         image_height_ff  <= RST_IMAGE_HEIGHT;
         channel_count_ff <= RST_CHANNEL_COUNT;
         coef_top_ff      <= RST_COEF_TOP;
         coef_mid_ff      <= RST_COEF_MID;
         coef_bot_ff      <= RST_COEF_BOT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata[HEIGHT_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHAN_W-1:0];
            CSR_COEF_TOP_ROW:  coef_top_ff      <= csr_wdata;
            CSR_COEF_MID_ROW:  coef_mid_ff      <= csr_wdata;
            CSR_COEF_BOT_ROW:  coef_bot_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // credit: every sample taken pushes exactly one descriptor, so the queue
   // can never overflow while the count stays within its depth
   assign req_ready = occ_ff < OCC_W'(FIFO_DEPTH);
   assign accept    = req_valid && req_ready;
   assign occ_in    = occ_ff + OCC_W'(accept) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_comb begin
      coefs.top = coef_top_ff;
      coefs.mid = coef_mid_ff;
      coefs.bot = coef_bot_ff;
   end

   // counters and result flags
   cfsf_track u_track (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_beat      (req_beat),
      .image_width   (image_width_ff),
      .image_height  (image_height_ff),
      .channel_count (channel_count_ff),
      .pos           (pos)
   );

   // line memory read-modify-write, window and products
   cfsf_window u_window (
      .clock (clock),
      .reset (reset),
      .pos   (pos),
      .coefs (coefs),
      .prod  (prod)
   );

   // sum, clamp, descriptor
   cfsf_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .prod       (prod),
      .push_valid (push_valid),
      .push_desc  (push_desc)
   );

   // queue and beat sequencer
   cfsf_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_beat   (rsp_beat)
   );

   `CFSF_ASSERT_IMP(a_credit_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(FIFO_DEPTH))
   `CFSF_ASSERT_IMP(a_pop_has_credit, clock, reset, pop, occ_ff != '0)

endmodule
